// ----- rtl/csf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the counting scale filter
// no dependencies; used by csf_div and counting_scale_filter_unit
package csf_pkg;

   localparam int SAMPLE_W           = 24;
   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int COUNT_W            = 8;
   localparam int SUM_W              = 32;
   localparam int REF_W              = 16;
   localparam int QTY_W              = 16;
   localparam int PEND_W             = 3;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 24;

   // serial divider sizes
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 24;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 120;

   // register reset values
   localparam logic [COUNT_W-1:0]  TICK_DIVIDE_RESET   = 8'd5;
   localparam logic [SAMPLE_W-1:0] JUMP_LIMIT_RESET    = 24'd4096;
   localparam logic [COUNT_W-1:0]  WINDOW_LENGTH_RESET = 8'd16;
   localparam logic [COUNT_W-1:0]  ERROR_LIMIT_RESET   = 8'd50;

   localparam logic [COUNT_W-1:0] MISS_MAX     = 8'hFF;
   localparam logic [QTY_W-1:0]   QUANTITY_SAT = 16'hFFFF;

   // bit positions in the pending request word
   localparam int PEND_ORIGIN = 0;
   localparam int PEND_CALIB  = 1;
   localparam int PEND_COUNT  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TICK_DIVIDE,
      CSR_JUMP_LIMIT,
      CSR_WINDOW_LENGTH,
      CSR_ERROR_LIMIT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_WIN,
      ST_AVG,
      ST_ORIGIN,
      ST_PAN,
      ST_CALIB,
      ST_CALIB_WAIT,
      ST_COUNT,
      ST_COUNT_WAIT,
      ST_OUT
   } csf_state_type;

   // input beat, last field in the lowest bits
   typedef struct packed {
      logic [2:0]          pad;
      logic                clear;
      logic [REF_W-1:0]    ref_pieces;
      logic                req_count;
      logic                req_calib;
      logic                req_origin;
      logic                sample_ready;
      logic [SAMPLE_W-1:0] sample;
   } req_item_type;

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [4:0]          pad;
      logic [QTY_W-1:0]    quantity;
      logic [SAMPLE_W-1:0] weight_per_piece;
      logic [SAMPLE_W-1:0] tare_origin;
      logic                window_done;
      logic                filtered_valid;
      logic [SAMPLE_W-1:0] filtered_weight;
      logic                live_valid;
      logic [SAMPLE_W-1:0] live_sample;
   } rsp_item_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/csf_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, shared by the filter
// depends on csf_pkg
module csf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  csf_pkg::div_req_type div_req,
   output csf_pkg::div_rsp_type div_rsp
);
   import csf_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      fits      = rem_shift >= {1'b0, dvs_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/counting_scale_filter_unit.sv -----
`timescale 1ns / 1ps
// counting scale filter: sample divider, window average, tare, piece weight and count
// depends on csf_pkg and csf_div
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------
//  req_    | in  | req_tvalid / req_tready    | req_tdata  48 bits, one item per beat
//  rsp_    | out | rsp_tvalid / rsp_tready    | rsp_tdata 120 bits, one result per item
//  csr_    | in  | csr_valid / csr_ready      | csr_index 2 bits, csr_data 24 bits
//
// an item is taken in idle, then passes tick, origin, pan, calib, count and out; win is added
// when a sample is compared with the previous one, and each division on the shared serial
// divider (window average, piece weight, piece count) adds its wait (avg, calib_wait, count_wait)
// one item is worked on at a time; the next is taken while the result register waits
// reset is synchronous and needs no clearing pass; csr writes are always taken
module counting_scale_filter_unit #(
   parameter int SAMPLE_BITS = csf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample[23:0], sample_ready[24], req_origin[25], req_calib[26], req_count[27],
   // ref_pieces[43:28], clear[44], zero fill[47:45]
   input  logic [csf_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // live_sample[23:0], live_valid[24], filtered_weight[48:25], filtered_valid[49],
   // window_done[50], tare_origin[74:51], weight_per_piece[98:75], quantity[114:99],
   // zero fill[119:115]
   output logic [csf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import csf_pkg::*;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - SAMPLE_BITS);

   csf_state_type state_ff, state_in;

   // configuration
   logic [COUNT_W-1:0]  tick_div_ff, tick_div_in;
   logic [SAMPLE_W-1:0] jump_lim_ff, jump_lim_in;
   logic [COUNT_W-1:0]  win_len_ff, win_len_in;
   logic [COUNT_W-1:0]  err_lim_ff, err_lim_in;

   // filter state
   logic [COUNT_W-1:0]  tick_ff, tick_in;
   logic [COUNT_W-1:0]  scount_ff, scount_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [COUNT_W-1:0]  miss_ff, miss_in;
   logic [SAMPLE_W-1:0] filt_ff, filt_in;
   logic                filt_ok_ff, filt_ok_in;
   logic [SAMPLE_W-1:0] origin_ff, origin_in;
   logic [SAMPLE_W-1:0] pw_ff, pw_in;
   logic [QTY_W-1:0]    qty_ff, qty_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic [SAMPLE_W:0]   live_ff, live_in;
   logic                done_ff, done_in;

   // latched item and working values
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                rdy_ff, rdy_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic [SAMPLE_W-1:0] delta_ff, delta_in;
   logic [SAMPLE_W:0]   pan_ff, pan_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   req_item_type        req_item;
   rsp_item_type        rsp_item;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [COUNT_W-1:0]  next_count;
   logic [SUM_W-1:0]    next_sum;
   logic                pan_above;

   csf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_item = req_item_type'(req_tdata);

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      tick_div_in = tick_div_ff;
      jump_lim_in = jump_lim_ff;
      win_len_in  = win_len_ff;
      err_lim_in  = err_lim_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICK_DIVIDE:   tick_div_in = csr_data[COUNT_W-1:0];
            CSR_JUMP_LIMIT:    jump_lim_in = csr_data[SAMPLE_W-1:0];
            CSR_WINDOW_LENGTH: win_len_in  = csr_data[COUNT_W-1:0];
            CSR_ERROR_LIMIT:   err_lim_in  = csr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      rsp_item                  = '0;
      rsp_item.live_sample      = live_ff[SAMPLE_W-1:0];
      rsp_item.live_valid       = live_ff[SAMPLE_W];
      rsp_item.filtered_weight  = filt_ff;
      rsp_item.filtered_valid   = filt_ok_ff;
      rsp_item.window_done      = done_ff;
      rsp_item.tare_origin      = origin_ff;
      rsp_item.weight_per_piece = pw_ff;
      rsp_item.quantity         = qty_ff;
   end

   assign next_count = scount_ff + 1'b1;
   assign next_sum   = sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, smp_ff};
   assign pan_above  = !pan_ff[SAMPLE_W] && (pan_ff[SAMPLE_W-1:0] != '0);

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      scount_in    = scount_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      miss_in      = miss_ff;
      filt_in      = filt_ff;
      filt_ok_in   = filt_ok_ff;
      origin_in    = origin_ff;
      pw_in        = pw_ff;
      qty_in       = qty_ff;
      pend_in      = pend_ff;
      live_in      = live_ff;
      done_in      = done_ff;
      smp_in       = smp_ff;
      rdy_in       = rdy_ff;
      ref_in       = ref_ff;
      delta_in     = delta_ff;
      pan_in       = pan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               smp_in  = req_item.sample & SAMPLE_MASK;
               rdy_in  = req_item.sample_ready;
               ref_in  = req_item.ref_pieces;
               done_in = 1'b0;
               if (req_item.clear) begin
                  tick_in    = '0;
                  scount_in  = '0;
                  sum_in     = '0;
                  prev_in    = '0;
                  miss_in    = '0;
                  filt_in    = '0;
                  filt_ok_in = 1'b1;
                  origin_in  = '0;
                  pw_in      = '0;
                  qty_in     = '0;
                  live_in    = '0;
               end
               pend_in = (req_item.clear ? '0 : pend_ff)
                       | {req_item.req_count, req_item.req_calib, req_item.req_origin};
               state_in = ST_TICK;
            end
         end

         ST_TICK: begin
            state_in = ST_ORIGIN;
            if (tick_ff >= tick_div_ff) begin
               tick_in = '0;
               if (rdy_ff) begin
                  live_in = {1'b1, smp_ff};
                  miss_in = '0;
                  if (scount_ff == '0) begin
                     // first sample of a window is only stored
                     sum_in    = {{(SUM_W-SAMPLE_W){1'b0}}, smp_ff};
                     prev_in   = smp_ff;
                     scount_in = COUNT_W'(1);
                  end else begin
                     delta_in = (prev_ff > smp_ff) ? prev_ff - smp_ff : smp_ff - prev_ff;
                     state_in = ST_WIN;
                  end
               end else begin
                  live_in = '0;
                  if (miss_ff > err_lim_ff) begin
                     scount_in  = '0;
                     sum_in     = '0;
                     filt_ok_in = 1'b0;
                     miss_in    = '0;
                  end else if (miss_ff < MISS_MAX) begin
                     miss_in = miss_ff + 1'b1;
                  end
               end
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end

         ST_WIN: begin
            state_in = ST_ORIGIN;
            if (delta_ff > jump_lim_ff) begin
               filt_ok_in = 1'b0;
               scount_in  = '0;
               sum_in     = '0;
            end else begin
               prev_in = smp_ff;
               if (next_count >= win_len_ff && next_count != '0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = next_sum;
                  div_req.divisor  = {{(DIVISOR_W-COUNT_W){1'b0}}, next_count};
                  scount_in        = '0;
                  sum_in           = '0;
                  state_in         = ST_AVG;
               end else begin
                  sum_in    = next_sum;
                  scount_in = next_count;
               end
            end
         end

         ST_AVG: begin
            if (div_rsp.done) begin
               filt_in    = div_rsp.quotient[SAMPLE_W-1:0];
               filt_ok_in = 1'b1;
               done_in    = 1'b1;
               state_in   = ST_ORIGIN;
            end
         end

         ST_ORIGIN: begin
            if (pend_ff[PEND_ORIGIN] && filt_ok_ff && filt_ff != '0) begin
               origin_in            = filt_ff;
               pend_in[PEND_ORIGIN] = 1'b0;
            end
            state_in = ST_PAN;
         end

         ST_PAN: begin
            // net load above tare, top bit is the borrow
            pan_in   = {1'b0, filt_ff} - {1'b0, origin_ff};
            state_in = ST_CALIB;
         end

         ST_CALIB: begin
            state_in = ST_COUNT;
            if (pend_ff[PEND_CALIB] && filt_ok_ff && origin_ff != '0
                && ref_ff != '0 && pan_above) begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(DIVIDEND_W-SAMPLE_W){1'b0}}, pan_ff[SAMPLE_W-1:0]};
               div_req.divisor  = {{(DIVISOR_W-REF_W){1'b0}}, ref_ff};
               state_in         = ST_CALIB_WAIT;
            end
         end

         ST_CALIB_WAIT: begin
            if (div_rsp.done) begin
               pw_in               = div_rsp.quotient[SAMPLE_W-1:0];
               pend_in[PEND_CALIB] = 1'b0;
               state_in            = ST_COUNT;
            end
         end

         ST_COUNT: begin
            state_in = ST_OUT;
            if (pend_ff[PEND_COUNT] && filt_ok_ff && origin_ff != '0) begin
               pend_in[PEND_COUNT] = 1'b0;
               if (!pan_above) begin
                  qty_in = '0;
               end else if (pw_ff == '0) begin
                  qty_in = QUANTITY_SAT;
               end else begin
                  // rounded by adding half a piece before dividing
                  div_req.start    = 1'b1;
                  div_req.dividend = {{(DIVIDEND_W-SAMPLE_W){1'b0}}, pan_ff[SAMPLE_W-1:0]}
                                   + {{(DIVIDEND_W-SAMPLE_W+1){1'b0}}, pw_ff[SAMPLE_W-1:1]};
                  div_req.divisor  = pw_ff;
                  state_in         = ST_COUNT_WAIT;
               end
            end
         end

         ST_COUNT_WAIT: begin
            if (div_rsp.done) begin
               qty_in = (div_rsp.quotient[DIVIDEND_W-1:QTY_W] != '0)
                      ? QUANTITY_SAT : div_rsp.quotient[QTY_W-1:0];
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = rsp_item;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff  <= TICK_DIVIDE_RESET;
         jump_lim_ff  <= JUMP_LIMIT_RESET;
         win_len_ff   <= WINDOW_LENGTH_RESET;
         err_lim_ff   <= ERROR_LIMIT_RESET;
         tick_ff      <= '0;
         scount_ff    <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         miss_ff      <= '0;
         filt_ff      <= '0;
         filt_ok_ff   <= 1'b1;
         origin_ff    <= '0;
         pw_ff        <= '0;
         qty_ff       <= '0;
         pend_ff      <= '0;
         live_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_div_ff  <= tick_div_in;
         jump_lim_ff  <= jump_lim_in;
         win_len_ff   <= win_len_in;
         err_lim_ff   <= err_lim_in;
         tick_ff      <= tick_in;
         scount_ff    <= scount_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         miss_ff      <= miss_in;
         filt_ff      <= filt_in;
         filt_ok_ff   <= filt_ok_in;
         origin_ff    <= origin_in;
         pw_ff        <= pw_in;
         qty_ff       <= qty_in;
         pend_ff      <= pend_in;
         live_ff      <= live_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      rdy_ff      <= rdy_in;
      ref_ff      <= ref_in;
      delta_ff    <= delta_in;
      pan_ff      <= pan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- tb/sv/counting_scale_filter_unit_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for counting_scale_filter_unit: directed and random weighing beats,
// predicted expectations compared with every result beat; depends on csf_pkg and the rtl
module counting_scale_filter_unit_test;
   import csf_pkg::*;

   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [PEND_W-1:0] ASK_NONE   = '0;
   localparam logic [PEND_W-1:0] ASK_ORIGIN = PEND_W'(1 << PEND_ORIGIN);
   localparam logic [PEND_W-1:0] ASK_CALIB  = PEND_W'(1 << PEND_CALIB);
   localparam logic [PEND_W-1:0] ASK_COUNT  = PEND_W'(1 << PEND_COUNT);

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_TICK_DIVIDE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   counting_scale_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #5 clock = ~clock;

   req_item_type item_queue[$];
   rsp_item_type scale_expect[$];
   int  fail_count  = 0;
   int  quiet_count = 0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   bit  idle_on     = 1'b1;

   // register copies
   logic [COUNT_W-1:0]  cfg_tick_divide   = TICK_DIVIDE_RESET;
   logic [SAMPLE_W-1:0] cfg_jump_limit    = JUMP_LIMIT_RESET;
   logic [COUNT_W-1:0]  cfg_window_length = WINDOW_LENGTH_RESET;
   logic [COUNT_W-1:0]  cfg_error_limit   = ERROR_LIMIT_RESET;

   // filter state as the block should hold it
   logic [COUNT_W-1:0]  tick_cnt;
   logic [COUNT_W-1:0]  fill_cnt;
   logic [SUM_W-1:0]    win_sum;
   logic [SAMPLE_W-1:0] prev_smp;
   logic [COUNT_W-1:0]  miss_cnt;
   logic [SAMPLE_W-1:0] avg_value;
   logic                avg_ok;
   logic [SAMPLE_W-1:0] origin;
   logic [SAMPLE_W-1:0] unit_weight;
   logic [QTY_W-1:0]    pieces;
   logic [PEND_W-1:0]   pend;
   logic [SAMPLE_W-1:0] live_smp;
   logic                live_ok;

   task automatic clear_filter();
      tick_cnt    = '0;
      fill_cnt    = '0;
      win_sum     = '0;
      prev_smp    = '0;
      miss_cnt    = '0;
      avg_value   = '0;
      avg_ok      = 1'b1;
      origin      = '0;
      unit_weight = '0;
      pieces      = '0;
      pend        = '0;
      live_smp    = '0;
      live_ok     = 1'b0;
   endtask

   task automatic predict_weighing(input req_item_type it);
      rsp_item_type        beat;
      logic [SAMPLE_W-1:0] diff;
      logic [SUM_W-1:0]    net;
      logic [SUM_W-1:0]    quot;
      logic                done;
      done = 1'b0;
      if (it.clear) clear_filter();
      pend = pend | {it.req_count, it.req_calib, it.req_origin};
      if (tick_cnt >= cfg_tick_divide) begin
         tick_cnt = '0;
         if (it.sample_ready) begin
            live_smp = it.sample;
            live_ok  = 1'b1;
            miss_cnt = '0;
            if (fill_cnt == 0) begin
               win_sum  = {{(SUM_W-SAMPLE_W){1'b0}}, it.sample};
               prev_smp = it.sample;
               fill_cnt = 8'd1;
            end else begin
               diff = (prev_smp > it.sample) ? prev_smp - it.sample : it.sample - prev_smp;
               if (diff > cfg_jump_limit) begin
                  avg_ok   = 1'b0;
                  fill_cnt = '0;
                  win_sum  = '0;
               end else begin
                  win_sum  = win_sum + {{(SUM_W-SAMPLE_W){1'b0}}, it.sample};
                  prev_smp = it.sample;
                  fill_cnt = fill_cnt + 1'b1;
                  if (fill_cnt >= cfg_window_length && fill_cnt != 0) begin
                     quot      = win_sum / {{(SUM_W-COUNT_W){1'b0}}, fill_cnt};
                     avg_value = quot[SAMPLE_W-1:0];
                     avg_ok    = 1'b1;
                     fill_cnt  = '0;
                     win_sum   = '0;
                     done      = 1'b1;
                  end
               end
            end
         end else begin
            live_smp = '0;
            live_ok  = 1'b0;
            if (miss_cnt > cfg_error_limit) begin
               fill_cnt = '0;
               win_sum  = '0;
               avg_ok   = 1'b0;
               miss_cnt = '0;
            end else if (miss_cnt != MISS_MAX) begin
               miss_cnt = miss_cnt + 1'b1;
            end
         end
      end else begin
         tick_cnt = tick_cnt + 1'b1;
      end

      // requests are served in the order origin, calibration, count
      if (pend[PEND_ORIGIN] && avg_ok && avg_value != 0) begin
         origin           = avg_value;
         pend[PEND_ORIGIN] = 1'b0;
      end
      if (pend[PEND_CALIB] && avg_ok && origin != 0 && it.ref_pieces != 0
          && avg_value > origin) begin
         unit_weight      = (avg_value - origin) / it.ref_pieces;
         pend[PEND_CALIB] = 1'b0;
      end
      if (pend[PEND_COUNT] && avg_ok && origin != 0) begin
         if (avg_value <= origin) begin
            pieces = '0;
         end else if (unit_weight == 0) begin
            pieces = QUANTITY_SAT;
         end else begin
            net    = {{(SUM_W-SAMPLE_W){1'b0}}, avg_value - origin};
            quot   = (net + {{(SUM_W-SAMPLE_W+1){1'b0}}, unit_weight[SAMPLE_W-1:1]})
                   / {{(SUM_W-SAMPLE_W){1'b0}}, unit_weight};
            pieces = (quot > {{(SUM_W-QTY_W){1'b0}}, QUANTITY_SAT})
                   ? QUANTITY_SAT : quot[QTY_W-1:0];
         end
         pend[PEND_COUNT] = 1'b0;
      end

      beat                  = '0;
      beat.live_sample      = live_ok ? live_smp : '0;
      beat.live_valid       = live_ok;
      beat.filtered_weight  = avg_value;
      beat.filtered_valid   = avg_ok;
      beat.window_done      = done;
      beat.tare_origin      = origin;
      beat.weight_per_piece = unit_weight;
      beat.quantity         = pieces;
      scale_expect.push_back(beat);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // sender: one beat held until taken, random gaps after a beat while idling is on
   always @(posedge clock) begin : drive_req
      logic fire;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) predict_weighing(req_item_type'(req_tdata));
         if (fire || !req_tvalid) begin
            if (fire && idle_on && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 18);
            if (gap_left != 0) begin
               gap_left--;
               next_valid = 1'b0;
            end else if (item_queue.size() != 0) begin
               req_tdata <= item_queue.pop_front();
               next_valid = 1'b1;
            end else begin
               next_valid = 1'b0;
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // receiver back-pressure bursts
   always @(posedge clock) begin
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 11) == 0)
         stall_left = $urandom_range(1, 18);
      rsp_tready <= !reset && stall_left == 0;
   end

   always @(posedge clock) begin : watch_rsp
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scale_expect.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("result beat with no item waiting: %h", rsp_tdata);
         end else begin
            want = scale_expect.pop_front();
            got  = rsp_item_type'(rsp_tdata);
            check_field("live_sample", 32'(want.live_sample), 32'(got.live_sample));
            check_field("live_valid", 32'(want.live_valid), 32'(got.live_valid));
            check_field("filtered_weight", 32'(want.filtered_weight),
                        32'(got.filtered_weight));
            check_field("filtered_valid", 32'(want.filtered_valid),
                        32'(got.filtered_valid));
            check_field("window_done", 32'(want.window_done), 32'(got.window_done));
            check_field("tare_origin", 32'(want.tare_origin), 32'(got.tare_origin));
            check_field("weight_per_piece", 32'(want.weight_per_piece),
                        32'(got.weight_per_piece));
            check_field("quantity", 32'(want.quantity), 32'(got.quantity));
            check_field("zero fill", 32'(want.pad), 32'(got.pad));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TICK_DIVIDE:   cfg_tick_divide   = value[COUNT_W-1:0];
         CSR_JUMP_LIMIT:    cfg_jump_limit    = value[SAMPLE_W-1:0];
         CSR_WINDOW_LENGTH: cfg_window_length = value[COUNT_W-1:0];
         CSR_ERROR_LIMIT:   cfg_error_limit   = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // valid stays high across the four beats, lowered once at the end
   task automatic set_config(input logic [7:0] tick, input logic [23:0] jump,
                             input logic [7:0] window, input logic [7:0] errs);
      write_reg(CSR_TICK_DIVIDE, {{(CSR_DATA_W-8){1'b0}}, tick});
      write_reg(CSR_JUMP_LIMIT, jump);
      write_reg(CSR_WINDOW_LENGTH, {{(CSR_DATA_W-8){1'b0}}, window});
      write_reg(CSR_ERROR_LIMIT, {{(CSR_DATA_W-8){1'b0}}, errs});
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (item_queue.size() != 0 || req_tvalid || scale_expect.size() != 0);
      @(posedge clock);
   endtask

   task automatic push_item(input logic [23:0] smp, input logic rdy,
                            input logic [PEND_W-1:0] ask, input logic [15:0] refp,
                            input logic clr);
      req_item_type it;
      it              = '0;
      it.sample       = smp;
      it.sample_ready = rdy;
      it.req_origin   = ask[PEND_ORIGIN];
      it.req_calib    = ask[PEND_CALIB];
      it.req_count    = ask[PEND_COUNT];
      it.ref_pieces   = refp;
      it.clear        = clr;
      item_queue.push_back(it);
   endtask

   function automatic logic [23:0] pick(input logic [23:0] lo, input logic [23:0] hi,
                                        input logic [23:0] mid_lo,
                                        input logic [23:0] mid_hi);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return hi;
         default: return 24'($urandom_range(mid_lo, mid_hi));
      endcase
   endfunction

   // pan loads move in whole pieces around an empty-pan level, with small noise,
   // occasional wild samples, missing samples and requests
   task automatic gen_weighing(input int n_items);
      logic [23:0] base;
      logic [23:0] unit;
      logic [23:0] level;
      logic [23:0] amp;
      logic [23:0] smp;
      logic [15:0] refp;
      logic [PEND_W-1:0] ask;
      int pieces_on;
      base      = 24'($urandom_range(200, 2000000));
      unit      = 24'($urandom_range(1, 3000));
      pieces_on = 0;
      amp       = (cfg_jump_limit < 64) ? cfg_jump_limit >> 1 : 24'd32;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 24) == 0) pieces_on = $urandom_range(0, 400);
         level = 24'(base + pieces_on * unit);
         smp   = level - amp + 24'($urandom_range(0, 2 * amp));
         if ($urandom_range(0, 9) == 0) smp = 24'($urandom);
         ask = ASK_NONE;
         if ($urandom_range(0, pieces_on == 0 ? 3 : 15) == 0) ask = ask | ASK_ORIGIN;
         if ($urandom_range(0, 9) == 0) ask = ask | ASK_CALIB;
         if ($urandom_range(0, 5) == 0) ask = ask | ASK_COUNT;
         case ($urandom_range(0, 9))
            0:       refp = '0;
            1:       refp = '1;
            2:       refp = 16'($urandom);
            default: refp = (pieces_on == 0) ? 16'd1 : 16'(pieces_on);
         endcase
         push_item(smp, $urandom_range(0, 7) != 0, ask, refp, $urandom_range(0, 79) == 0);
      end
   endtask

   initial begin
      clear_filter();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // jumps, misses and the discard after too many misses
      set_config(8'd0, 24'd1000, 8'd1, 8'd0);
      push_item(24'd0, 1'b0, ASK_NONE, 16'd0, 1'b1);
      push_item(24'd0, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd1000, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd2001, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd3002, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd0, 1'b0, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd0, 1'b0, ASK_ORIGIN, 16'd0, 1'b0);
      wait_drained();

      // tare, calibration and counting, with the held requests and the saturations
      set_config(8'd0, 24'hFFFFFF, 8'd0, 8'd255);
      push_item(24'd5000, 1'b1, ASK_ORIGIN, 16'd0, 1'b1);
      push_item(24'd5000, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd5005, 1'b1, ASK_CALIB, 16'd0, 1'b0);
      push_item(24'd5005, 1'b1, ASK_NONE, 16'hFFFF, 1'b0);
      push_item(24'd5500, 1'b1, ASK_COUNT, 16'd7, 1'b0);
      push_item(24'd5505, 1'b1, ASK_CALIB, 16'd10, 1'b0);
      push_item(24'hFFFFFF, 1'b1, ASK_COUNT, 16'd0, 1'b0);
      push_item(24'hFFFFFF, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd0, 1'b1, ASK_COUNT, 16'd0, 1'b0);
      push_item(24'd0, 1'b1, ASK_NONE, 16'd0, 1'b0);
      push_item(24'd0, 1'b0, ASK_COUNT, 16'd0, 1'b0);
      wait_drained();

      // window shortened while partly filled: the next sample closes it
      set_config(8'd0, 24'hFFFFFF, 8'd255, 8'd255);
      for (int i = 0; i < 4; i++) push_item(24'(100 + i), 1'b1, ASK_NONE, 16'd0, 1'b0);
      wait_drained();
      set_config(8'd0, 24'hFFFFFF, 8'd2, 8'd255);
      push_item(24'd104, 1'b1, ASK_NONE, 16'd0, 1'b0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         if (p == 5) begin
            // long outage: the miss counter has to sit at its ceiling
            set_config(8'd0, pick(24'd0, 24'hFFFFFF, 24'd16, 24'd4096),
                       8'(pick(24'd1, 24'd255, 24'd1, 24'd8)), 8'd255);
            idle_on = 1'b1;
            for (int i = 0; i < 262; i++)
               push_item(24'($urandom), i >= 256, PEND_W'($urandom_range(0, 7)),
                         16'($urandom), 1'b0);
         end else begin
            set_config(8'(pick(24'd0, 24'd255, 24'd0, 24'd3)),
                       pick(24'd0, 24'hFFFFFF, 24'd16, 24'd4096),
                       8'(pick(24'd1, 24'd255, 24'd1, 24'd8)),
                       8'(pick(24'd0, 24'd255, 24'd0, 24'd12)));
            idle_on = (p != 3 && p != 7);
            gen_weighing(36);
         end
         wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && scale_expect.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/csf_pkg.sv
rtl/csf_div.sv
rtl/counting_scale_filter_unit.sv
tb/sv/counting_scale_filter_unit_test.sv
